@@ hdl/fcce_pkg.sv @@
// ============================================================================
// fcce_pkg
// Shared types, constants and entry helpers for the cluster chain engine.
// ============================================================================
package fcce_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_CHAIN   = 4;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LIM_W       = ADDR_W + 1;
    localparam int CHAIN_W     = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int GOT_W       = $clog2(MAX_CHAIN + 1);

    localparam logic [31:0] EOC_CODE = 32'h0FFF_FFFF;
    localparam logic [31:0] BAD16    = 32'h0000_FFF7;
    localparam logic [31:0] BAD32    = 32'h0FFF_FFF7;
    localparam logic [31:0] EOC16    = 32'h0000_FFFF;
    localparam logic [12:0] FREE_MAX = 13'd8191;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_ALLOC = 3'd2;
    localparam logic [2:0] CMD_FREE  = 3'd3;
    localparam logic [2:0] CMD_COUNT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADIDX  = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_FREELNK = 2'd3;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_FIRST = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;

    // stored entry as seen by the chain logic
    function automatic logic [31:0] f_decode(input logic [31:0] raw, input logic mode);
        logic [31:0] v;
        v = raw;
        if (!mode) begin
            v = {16'h0, raw[15:0]};
            if (v >= BAD16) v = EOC_CODE;
        end else if (v >= BAD32) begin
            v = EOC_CODE;
        end
        return v;
    endfunction

    // value to store for a write
    function automatic logic [31:0] f_put(input logic [31:0] val, input logic mode);
        logic [31:0] v;
        v = val;
        if (v == EOC_CODE) v = mode ? EOC_CODE : EOC16;
        if (!mode) v = {16'h0, v[15:0]};
        return v;
    endfunction

endpackage

@@ hdl/fcce_ram.sv @@
// ============================================================================
// fcce_ram
// Single write port, single read port table memory with registered read.
// ============================================================================
module fcce_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/fat_cluster_chain_engine.sv @@
// ============================================================================
// fat_cluster_chain_engine
// Cluster allocation table engine: read, write, chain allocate, chain free,
// free count, over one table memory driven by a small sequencer.
// ============================================================================
// Table accesses share the single read port: free walks the chain link by
//   link, count reads each entry in range, allocate scans entries and writes
//   each chain link, and a successful allocation emits one result per cluster.
// Throughput: one transaction at a time; o_stall is low only when idle.
// Reset: synchronous active low; afterward a clearing pass writes zero to all
//   TABLE_DEPTH entries before the first transaction is taken.
module fat_cluster_chain_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [11:0] i_index,
    input  logic [31:0] i_value,
    input  logic [2:0]  i_request_count,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_entry_value,
    output logic [11:0] o_cluster,
    output logic [12:0] o_free_count,
    output logic        o_free_known,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fcce_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_ARD, S_ACHK, S_ALNK, S_FCHK, S_FDAT, S_CRD, S_CCHK, S_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    logic        r_width;
    t_addr       r_first;
    logic [12:0] r_limit;

    // persistent engine state
    t_addr       r_last_alloc;
    logic [12:0] r_free;
    logic        r_known;
    t_addr       r_found [MAX_CHAIN];

    // per-transaction working registers
    t_addr            r_e;
    logic [LIM_W-1:0] r_scan;
    logic [LIM_W-1:0] r_total;
    logic [GOT_W-1:0] r_got;
    logic [GOT_W-1:0] r_n;
    t_addr            r_prev;
    t_addr            r_lnk_addr;
    t_addr            r_lnk_dat;
    t_addr            r_cur;
    logic             r_big;
    logic             r_fail;
    logic [12:0]      r_cnt;
    // result staging
    logic [1:0]       r_st;
    logic [31:0]      r_val;
    logic             r_alloc_out;
    logic [GOT_W-1:0] r_nout;
    logic [GOT_W-1:0] r_k;

    logic             mem_we;
    t_addr            mem_waddr;
    logic [31:0]      mem_wdata;
    t_addr            mem_raddr;
    logic [31:0]      mem_rdata;

    fcce_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(32)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH: prdata = {31'h0, r_width};
            REG_FIRST: prdata = {{(32-ADDR_W){1'b0}}, r_first};
            REG_LIMIT: prdata = {19'h0, r_limit};
            default:   prdata = 32'h0;
        endcase
    end

    // effective limit = min(entry_limit, TABLE_DEPTH)
    logic [LIM_W-1:0] lim;
    assign lim = (r_limit > 13'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : LIM_W'(r_limit);

    logic             in_acc, out_free, idx_ok, range_ok, cur_ok;
    logic [LIM_W-1:0] start_p1, e_p1;
    t_addr            start_e, e_next;
    logic [GOT_W-1:0] req_sat;
    logic [31:0]      rd_dec;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign range_ok = {1'b0, r_first} < lim;
    assign idx_ok   = (i_index >= r_first) && ({1'b0, i_index} < lim);
    assign cur_ok   = !r_big && (r_cur >= r_first) && ({1'b0, r_cur} < lim);
    assign rd_dec   = f_decode(mem_rdata, r_width);

    // next-fit start, wrapping to first entry
    assign start_p1 = {1'b0, r_last_alloc} + 1'b1;
    assign start_e  = (start_p1 >= lim || start_p1 < {1'b0, r_first})
                      ? r_first : start_p1[ADDR_W-1:0];
    assign e_p1     = {1'b0, r_e} + 1'b1;
    assign e_next   = (e_p1 >= lim) ? r_first : e_p1[ADDR_W-1:0];
    assign req_sat  = (i_request_count > 3'(MAX_CHAIN)) ? GOT_W'(MAX_CHAIN)
                                                         : GOT_W'(i_request_count);

    logic found;
    assign found = (r_state == S_ACHK) && (rd_dec == 32'h0);

    // table write and read port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_e;
        mem_wdata = 32'h0;
        mem_raddr = r_e;
        case (r_state)
            S_CLR:  mem_we = 1'b1;
            S_IDLE: begin
                mem_raddr = i_index;
                mem_waddr = i_index;
                mem_wdata = f_put(i_value, r_width);
                mem_we    = in_acc && (i_command == CMD_WRITE) && idx_ok;
            end
            S_ACHK: begin
                mem_we    = found;
                mem_wdata = f_put(EOC_CODE, r_width);
            end
            S_ALNK: begin
                mem_we    = 1'b1;
                mem_waddr = r_lnk_addr;
                mem_wdata = {{(32-ADDR_W){1'b0}}, r_lnk_dat};
            end
            S_FCHK: mem_raddr = r_cur;
            S_FDAT: begin
                mem_waddr = r_cur;
                mem_we    = (rd_dec != 32'h0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_e          <= '0;
            r_width      <= 1'b1;
            r_first      <= ADDR_W'(2);
            r_limit      <= 13'd4096;
            r_last_alloc <= '0;
            r_free       <= '0;
            r_known      <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_WIDTH: r_width <= pwdata[0];
                    REG_FIRST: r_first <= pwdata[ADDR_W-1:0];
                    REG_LIMIT: r_limit <= pwdata[12:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;

            case (r_state)
                S_CLR: begin
                    r_e <= r_e + 1'b1;
                    if (r_e == ADDR_W'(TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_val       <= '0;
                    r_st        <= ST_OK;
                    r_nout      <= GOT_W'(1);
                    r_k         <= '0;
                    r_alloc_out <= 1'b0;
                    r_fail      <= 1'b0;
                    if (in_acc) begin
                        case (i_command)
                            CMD_READ: begin
                                if (idx_ok) r_state <= S_RD;
                                else begin
                                    r_st    <= ST_BADIDX;
                                    r_state <= S_EMIT;
                                end
                            end
                            CMD_WRITE: begin
                                if (idx_ok) r_val <= f_put(i_value, r_width);
                                else r_st <= ST_BADIDX;
                                r_state <= S_EMIT;
                            end
                            CMD_ALLOC: begin
                                r_n     <= req_sat;
                                r_got   <= '0;
                                r_scan  <= '0;
                                r_e     <= start_e;
                                r_total <= range_ok ? (lim - {1'b0, r_first}) : '0;
                                if (req_sat == '0) r_state <= S_EMIT;
                                else if (r_known && r_free < 13'(req_sat)) begin
                                    r_st    <= ST_NOSPACE;
                                    r_state <= S_EMIT;
                                end else if (!range_ok) begin
                                    // nothing to scan: fail with empty chain
                                    r_free  <= '0;
                                    r_known <= 1'b1;
                                    r_st    <= ST_NOSPACE;
                                    r_state <= S_EMIT;
                                end else r_state <= S_ARD;
                            end
                            CMD_FREE: begin
                                r_cur   <= i_index;
                                r_big   <= 1'b0;
                                r_state <= S_FCHK;
                            end
                            CMD_COUNT: begin
                                r_e   <= r_first;
                                r_cnt <= '0;
                                if (r_known) r_state <= S_EMIT;
                                else if (!range_ok) begin
                                    r_free  <= '0;
                                    r_known <= 1'b1;
                                    r_state <= S_EMIT;
                                end else r_state <= S_CRD;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_RD: begin
                    r_val   <= rd_dec;
                    r_state <= S_EMIT;
                end
                // allocation scan
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    r_scan <= r_scan + 1'b1;
                    r_e    <= e_next;
                    if (found) begin
                        r_found[r_got[CHAIN_W-1:0]] <= r_e;
                        r_last_alloc <= r_e;
                        r_prev       <= r_e;
                        r_lnk_addr   <= r_prev;
                        r_lnk_dat    <= r_e;
                        r_got        <= r_got + 1'b1;
                        if (r_known && r_free != 13'd0) r_free <= r_free - 1'b1;
                    end
                    if (found && r_got != '0) r_state <= S_ALNK;
                    else if (found && (r_got + 1'b1) == r_n) begin
                        r_alloc_out <= 1'b1;
                        r_nout      <= r_n;
                        r_state     <= S_EMIT;
                    end else if (r_scan + 1'b1 == r_total) begin
                        r_free  <= '0;
                        r_known <= 1'b1;
                        r_fail  <= 1'b1;
                        // a lone cluster found on the last entry is the chain head
                        r_cur   <= found ? r_e : r_found[0];
                        r_big   <= 1'b0;
                        r_st    <= ST_NOSPACE;
                        r_state <= (found || r_got != '0) ? S_FCHK : S_EMIT;
                    end else r_state <= S_ARD;
                end
                S_ALNK: begin
                    if (r_got == r_n) begin
                        r_alloc_out <= 1'b1;
                        r_nout      <= r_n;
                        r_state     <= S_EMIT;
                    end else if (r_scan == r_total) begin
                        // roll back the partial chain
                        r_free  <= '0;
                        r_known <= 1'b1;
                        r_fail  <= 1'b1;
                        r_cur   <= r_found[0];
                        r_big   <= 1'b0;
                        r_st    <= ST_NOSPACE;
                        r_state <= S_FCHK;
                    end else r_state <= S_ARD;
                end
                // chain walk for free and rollback
                S_FCHK: begin
                    if (cur_ok) r_state <= S_FDAT;
                    else begin
                        if (!r_fail) r_st <= ST_BADIDX;
                        r_state <= S_EMIT;
                    end
                end
                S_FDAT: begin
                    if (rd_dec == 32'h0) begin
                        if (!r_fail) r_st <= ST_FREELNK;
                        r_state <= S_EMIT;
                    end else begin
                        if (r_known && r_free < FREE_MAX) r_free <= r_free + 1'b1;
                        r_cur <= rd_dec[ADDR_W-1:0];
                        r_big <= (rd_dec[31:ADDR_W] != '0);
                        r_state <= (rd_dec == EOC_CODE) ? S_EMIT : S_FCHK;
                    end
                end
                // free count scan
                S_CRD: r_state <= S_CCHK;
                S_CCHK: begin
                    logic [12:0] cnt_n;
                    cnt_n = r_cnt + ((rd_dec == 32'h0) ? 13'd1 : 13'd0);
                    r_cnt <= cnt_n;
                    r_e   <= e_p1[ADDR_W-1:0];
                    if (e_p1 == lim) begin
                        r_free  <= cnt_n;
                        r_known <= 1'b1;
                        r_state <= S_EMIT;
                    end else r_state <= S_CRD;
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_status      <= r_st;
                        o_entry_value <= r_val;
                        o_cluster     <= r_alloc_out ? r_found[r_k[CHAIN_W-1:0]] : '0;
                        o_free_count  <= r_free;
                        o_free_known  <= r_known;
                        o_last        <= (r_k + 1'b1 == r_nout);
                        r_k           <= r_k + 1'b1;
                        if (r_k + 1'b1 == r_nout) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/fcce_checker.sv @@
// ============================================================================
// fcce_checker
// Port-level checks on the cluster chain engine result channel.
// ============================================================================
module fcce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [11:0] o_cluster,
    input logic [12:0] o_free_count,
    input logic        o_free_known,
    input logic        o_last
);
    import fcce_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_cluster == '0)
        else $error("error result not a lone final transaction");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_free_known |-> o_free_count == '0)
        else $error("free count nonzero while unknown");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_cluster   (o_cluster),
    .o_free_count(o_free_count),
    .o_free_known(o_free_known),
    .o_last      (o_last)
);
